FILE: rtl/vector3_alu_defines.svh
// ----------------------------------------------------------------------------
// vector3_alu_defines
// assertion macros shared by the vector unit rtl
// ----------------------------------------------------------------------------
`ifndef VECTOR3_ALU_DEFINES_SVH
`define VECTOR3_ALU_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define V3A_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vector3_alu: check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define V3A_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vector3_alu: check failed");

`endif

FILE: rtl/v3a_pkg.sv
// ----------------------------------------------------------------------------
// v3a_pkg
// operation codes shared by the vector unit modules
// ----------------------------------------------------------------------------
package v3a_pkg;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_NEG   = 4'd2,
    OP_SCALE = 4'd3,
    OP_DIV   = 4'd4,
    OP_DOT   = 4'd5,
    OP_CROSS = 4'd6,
    OP_MAG2  = 4'd7,
    OP_MAG   = 4'd8,
    OP_NORM  = 4'd9,
    OP_COMP  = 4'd10
  } v3a_op_t;

endpackage

FILE: rtl/v3a_lane.sv
// ----------------------------------------------------------------------------
// v3a_lane
// one vector component: products, add/sub/neg/scale/cross, component scaling
// ----------------------------------------------------------------------------
module v3a_lane #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                    clk,
  input  logic                    en,
  input  v3a_pkg::v3a_op_t        op_i,
  input  logic signed [W-1:0]     a_i,
  input  logic signed [W-1:0]     b_i,
  input  logic signed [W-1:0]     a_n1_i,
  input  logic signed [W-1:0]     b_n1_i,
  input  logic signed [W-1:0]     a_n2_i,
  input  logic signed [W-1:0]     b_n2_i,
  input  logic signed [W-1:0]     f_i,
  input  logic signed [W-1:0]     s_b_i,
  output logic signed [2*W-1:0]   ab_a_o,
  output logic signed [2*W-1:0]   aa_a_o,
  output logic signed [W-1:0]     a_d_o,
  output logic signed [W-1:0]     vec_d_o,
  output logic                    sat_d_o
);
  import v3a_pkg::*;

  localparam int XW = 2*W+3;
  localparam logic signed [XW-1:0] HI = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [XW-1:0] LO = {{(XW-W+1){1'b1}}, {(W-1){1'b0}}};

  // {clamped flag, value}
  function automatic logic [W:0] clamp(input logic signed [XW-1:0] x);
    if (x > HI) begin
      clamp = {1'b1, HI[W-1:0]};
    end else if (x < LO) begin
      clamp = {1'b1, LO[W-1:0]};
    end else begin
      clamp = {1'b0, x[W-1:0]};
    end
  endfunction

  v3a_op_t                op_a_r, op_b_r, op_c_r;
  logic signed [W-1:0]    a_a_r, a_b_r, a_c_r, a_d_r;
  logic signed [W-1:0]    b_a_r, b_b_r;
  logic signed [2*W-1:0]  ab_a_r, aa_a_r, af_a_r, c1_a_r, c2_a_r;
  logic signed [W:0]      as_a_r;
  logic signed [W-1:0]    vec_b_r, vec_c_r, vec_d_r;
  logic                   sat_b_r, sat_c_r, sat_d_r;
  logic signed [2*W-1:0]  bs_c_r;

  logic signed [2*W-1:0]  ab_nxt, aa_nxt, af_nxt, c1_nxt, c2_nxt, bs_nxt;
  logic signed [W:0]      as_nxt;
  logic [W:0]             cl_b, cl_d;
  logic signed [W-1:0]    vec_d_nxt;
  logic                   sat_d_nxt;

  assign ab_nxt = a_i * b_i;
  assign aa_nxt = a_i * a_i;
  assign af_nxt = a_i * f_i;
  assign c1_nxt = a_n1_i * b_n2_i;
  assign c2_nxt = a_n2_i * b_n1_i;
  assign bs_nxt = b_b_r * s_b_i;

  always_comb begin
    case (op_i)
      OP_ADD:  as_nxt = a_i + b_i;
      OP_SUB:  as_nxt = a_i - b_i;
      OP_NEG:  as_nxt = -a_i;
      default: as_nxt = '0;
    endcase
  end

  always_comb begin
    case (op_a_r)
      OP_ADD, OP_SUB, OP_NEG: cl_b = clamp(as_a_r);
      OP_SCALE:               cl_b = clamp(af_a_r >>> F);
      OP_CROSS:               cl_b = clamp((c1_a_r - c2_a_r) >>> F);
      default:                cl_b = '0;
    endcase
  end

  assign cl_d = clamp(bs_c_r >>> F);

  always_comb begin
    if (op_c_r == OP_COMP) begin
      vec_d_nxt = cl_d[W-1:0];
      sat_d_nxt = sat_c_r | cl_d[W];
    end else begin
      vec_d_nxt = vec_c_r;
      sat_d_nxt = sat_c_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_a_r  <= op_i;
      a_a_r   <= a_i;
      b_a_r   <= b_i;
      ab_a_r  <= ab_nxt;
      aa_a_r  <= aa_nxt;
      af_a_r  <= af_nxt;
      c1_a_r  <= c1_nxt;
      c2_a_r  <= c2_nxt;
      as_a_r  <= as_nxt;
      op_b_r  <= op_a_r;
      a_b_r   <= a_a_r;
      b_b_r   <= b_a_r;
      vec_b_r <= cl_b[W-1:0];
      sat_b_r <= cl_b[W];
      op_c_r  <= op_b_r;
      a_c_r   <= a_b_r;
      vec_c_r <= vec_b_r;
      sat_c_r <= sat_b_r;
      bs_c_r  <= bs_nxt;
      a_d_r   <= a_c_r;
      vec_d_r <= vec_d_nxt;
      sat_d_r <= sat_d_nxt;
    end
  end

  assign ab_a_o  = ab_a_r;
  assign aa_a_o  = aa_a_r;
  assign a_d_o   = a_d_r;
  assign vec_d_o = vec_d_r;
  assign sat_d_o = sat_d_r;

endmodule

FILE: rtl/v3a_merge.sv
// ----------------------------------------------------------------------------
// v3a_merge
// combines the lane products: dot, squared magnitude and sum of squares
// ----------------------------------------------------------------------------
module v3a_merge #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  v3a_pkg::v3a_op_t         op_i,
  input  logic signed [W-1:0]      f_i,
  input  logic [2:0][2*W-1:0]      ab_i,
  input  logic [2:0][2*W-1:0]      aa_i,
  output logic signed [W-1:0]      s_b_o,
  output v3a_pkg::v3a_op_t         op_d_o,
  output logic signed [W-1:0]      f_d_o,
  output logic signed [W-1:0]      s_d_o,
  output logic                     sat_d_o,
  output logic [2*W-1:0]           sq_d_o
);
  import v3a_pkg::*;

  localparam int XW = 2*W+3;
  localparam logic signed [XW-1:0] HI = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [XW-1:0] LO = {{(XW-W+1){1'b1}}, {(W-1){1'b0}}};

  function automatic logic [W:0] clamp(input logic signed [XW-1:0] x);
    if (x > HI) begin
      clamp = {1'b1, HI[W-1:0]};
    end else if (x < LO) begin
      clamp = {1'b1, LO[W-1:0]};
    end else begin
      clamp = {1'b0, x[W-1:0]};
    end
  endfunction

  v3a_op_t              op_a_r, op_b_r, op_c_r, op_d_r;
  logic signed [W-1:0]  f_a_r, f_b_r, f_c_r, f_d_r;
  logic signed [W-1:0]  s_b_r, s_c_r, s_d_r;
  logic                 sat_b_r, sat_c_r, sat_d_r;
  logic [2*W-1:0]       sq_b_r, sq_c_r, sq_d_r;

  logic signed [2*W+1:0] dot, mag;
  logic [2*W-1:0]        sq_nxt;
  logic [W:0]            cl;

  // exact sums, floor applied once by the arithmetic shift
  assign dot = $signed(ab_i[0]) + $signed(ab_i[1]) + $signed(ab_i[2]);
  assign mag = $signed(aa_i[0]) + $signed(aa_i[1]) + $signed(aa_i[2]);
  assign sq_nxt = aa_i[0] + aa_i[1] + aa_i[2];

  always_comb begin
    case (op_a_r)
      OP_DOT, OP_COMP: cl = clamp(dot >>> F);
      OP_MAG2:         cl = clamp(mag >>> F);
      default:         cl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_a_r  <= op_i;
      f_a_r   <= f_i;
      op_b_r  <= op_a_r;
      f_b_r   <= f_a_r;
      s_b_r   <= cl[W-1:0];
      sat_b_r <= cl[W];
      sq_b_r  <= sq_nxt;
      op_c_r  <= op_b_r;
      f_c_r   <= f_b_r;
      s_c_r   <= s_b_r;
      sat_c_r <= sat_b_r;
      sq_c_r  <= sq_b_r;
      op_d_r  <= op_c_r;
      f_d_r   <= f_c_r;
      s_d_r   <= s_c_r;
      sat_d_r <= sat_c_r;
      sq_d_r  <= sq_c_r;
    end
  end

  assign s_b_o   = s_b_r;
  assign op_d_o  = op_d_r;
  assign f_d_o   = f_d_r;
  assign s_d_o   = s_d_r;
  assign sat_d_o = sat_d_r;
  assign sq_d_o  = sq_d_r;

endmodule

FILE: rtl/v3a_sqrt.sv
// ----------------------------------------------------------------------------
// v3a_sqrt
// pipelined floor square root, one result bit per stage
// ----------------------------------------------------------------------------
module v3a_sqrt #(
  parameter int W  = 32,
  parameter int PW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            valid_i,
  input  logic [2*W-1:0]  rad_i,
  input  logic [PW-1:0]   pay_i,
  output logic            valid_o,
  output logic [W-1:0]    root_o,
  output logic [PW-1:0]   pay_o
);

  localparam int RW = W+2;

  logic [RW-1:0]   rem_r [W];
  logic [W-1:0]    root_r [W];
  logic [2*W-1:0]  rad_r [W];
  logic [PW-1:0]   pay_r [W];
  logic [W-1:0]    vld_r;

  logic [RW-1:0]   rem_s [W];
  logic [W-1:0]    root_s [W];
  logic [2*W-1:0]  rad_s [W];
  logic [PW-1:0]   pay_s [W];

  logic [RW-1:0]   rem_nxt [W];
  logic [W-1:0]    root_nxt [W];
  logic [2*W-1:0]  rad_nxt [W];

  for (genvar k = 0; k < W; k++) begin : g_src
    if (k == 0) begin : g_first
      assign rem_s[k]  = '0;
      assign root_s[k] = '0;
      assign rad_s[k]  = rad_i;
      assign pay_s[k]  = pay_i;
    end else begin : g_next
      assign rem_s[k]  = rem_r[k-1];
      assign root_s[k] = root_r[k-1];
      assign rad_s[k]  = rad_r[k-1];
      assign pay_s[k]  = pay_r[k-1];
    end
  end

  always_comb begin
    logic [RW+1:0] ext;
    logic [RW+1:0] trial;
    for (int k = 0; k < W; k++) begin
      ext   = {rem_s[k], rad_s[k][2*W-1 -: 2]};
      trial = {2'b00, root_s[k], 2'b01};
      if (ext >= trial) begin
        rem_nxt[k]  = RW'(ext - trial);
        root_nxt[k] = {root_s[k][W-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = ext[RW-1:0];
        root_nxt[k] = {root_s[k][W-2:0], 1'b0};
      end
      rad_nxt[k] = {rad_s[k][2*W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[W-2:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < W; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        rad_r[k]  <= rad_nxt[k];
        pay_r[k]  <= pay_s[k];
      end
    end
  end

  assign valid_o = vld_r[W-1];
  assign root_o  = root_r[W-1];
  assign pay_o   = pay_r[W-1];

endmodule

FILE: rtl/v3a_div.sv
// ----------------------------------------------------------------------------
// v3a_div
// three-lane pipelined restoring divider sharing one divisor
// ----------------------------------------------------------------------------
module v3a_div #(
  parameter int W  = 32,
  parameter int F  = 16,
  parameter int PW = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  valid_i,
  input  logic [W-1:0]          dvs_i,
  input  logic [2:0][W+F-1:0]   dvd_i,
  input  logic [PW-1:0]         pay_i,
  output logic                  valid_o,
  output logic [2:0][W+F-1:0]   quo_o,
  output logic [PW-1:0]         pay_o
);

  localparam int NB = W+F;

  logic [W-1:0]   rem_r [NB][3];
  logic [NB-1:0]  nq_r  [NB][3];
  logic [W-1:0]   dvs_r [NB];
  logic [PW-1:0]  pay_r [NB];
  logic [NB-1:0]  vld_r;

  logic [W-1:0]   rem_s [NB][3];
  logic [NB-1:0]  nq_s  [NB][3];
  logic [W-1:0]   dvs_s [NB];
  logic [PW-1:0]  pay_s [NB];

  logic [W-1:0]   rem_nxt [NB][3];
  logic [NB-1:0]  nq_nxt  [NB][3];

  for (genvar k = 0; k < NB; k++) begin : g_src
    if (k == 0) begin : g_first
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign rem_s[k][l] = '0;
        assign nq_s[k][l]  = dvd_i[l];
      end
      assign dvs_s[k] = dvs_i;
      assign pay_s[k] = pay_i;
    end else begin : g_next
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign rem_s[k][l] = rem_r[k-1][l];
        assign nq_s[k][l]  = nq_r[k-1][l];
      end
      assign dvs_s[k] = dvs_r[k-1];
      assign pay_s[k] = pay_r[k-1];
    end
  end

  // dividend bits shift out at the top while quotient bits shift in below
  always_comb begin
    logic [W:0] tr;
    for (int k = 0; k < NB; k++) begin
      for (int l = 0; l < 3; l++) begin
        tr = {rem_s[k][l], nq_s[k][l][NB-1]};
        if (tr >= {1'b0, dvs_s[k]}) begin
          rem_nxt[k][l] = W'(tr - {1'b0, dvs_s[k]});
          nq_nxt[k][l]  = {nq_s[k][l][NB-2:0], 1'b1};
        end else begin
          rem_nxt[k][l] = tr[W-1:0];
          nq_nxt[k][l]  = {nq_s[k][l][NB-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NB-2:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NB; k++) begin
        for (int l = 0; l < 3; l++) begin
          rem_r[k][l] <= rem_nxt[k][l];
          nq_r[k][l]  <= nq_nxt[k][l];
        end
        dvs_r[k] <= dvs_s[k];
        pay_r[k] <= pay_s[k];
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_out
    assign quo_o[l] = nq_r[NB-1][l];
  end

  assign valid_o = vld_r[NB-1];
  assign pay_o   = pay_r[NB-1];

endmodule

FILE: rtl/vector3_alu.sv
// ----------------------------------------------------------------------------
// vector3_alu
// Three-component fixed-point vector unit (add, sub, neg, scale, div, dot,
// cross, mag2, mag, norm, component), Q16.16 by default. One item enters per
// clock while the pipeline is not stalled, and each item gives exactly one
// result. The pipeline is the lane and merge stages for products, sums and the
// component scaling, the bit-per-stage square root, the bit-per-stage divider,
// and the output register. Every operation takes the full pipeline. When
// out_ready is low while a result is waiting the whole pipeline holds, so
// in_ready follows out_ready while a result is waiting. Products are floored,
// quotients truncate toward zero, results clamp to the word range with
// out_saturated set, a zero divisor in div gives a zero vector with
// out_divide_by_zero set, and norm of a zero vector gives x equal to one.
// ----------------------------------------------------------------------------
`include "vector3_alu_defines.svh"

module vector3_alu #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [3:0]                  in_operation,
  input  logic signed [WORD_BITS-1:0] in_a_x,
  input  logic signed [WORD_BITS-1:0] in_a_y,
  input  logic signed [WORD_BITS-1:0] in_a_z,
  input  logic signed [WORD_BITS-1:0] in_b_x,
  input  logic signed [WORD_BITS-1:0] in_b_y,
  input  logic signed [WORD_BITS-1:0] in_b_z,
  input  logic signed [WORD_BITS-1:0] in_factor,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [WORD_BITS-1:0] out_x,
  output logic signed [WORD_BITS-1:0] out_y,
  output logic signed [WORD_BITS-1:0] out_z,
  output logic signed [WORD_BITS-1:0] out_scalar,
  output logic                        out_saturated,
  output logic                        out_divide_by_zero
);
  import v3a_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int NB = W+F;
  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
  localparam bit           ONE_CLAMP = (F > W-2);
  localparam logic [W-1:0] NORM_ONE  = ONE_CLAMP ? WMAX : (W'(1) << F);

  typedef struct packed {
    v3a_op_t              op;
    logic                 sat;
    logic [W-1:0]         s;
    logic [2:0][W-1:0]    v;
    logic [2:0][W-1:0]    a;
    logic [W-1:0]         f;
  } sq_pay_t;

  typedef struct packed {
    v3a_op_t              op;
    logic                 sat;
    logic [W-1:0]         s;
    logic [2:0][W-1:0]    v;
    logic [2:0]           neg;
    logic                 zero;
  } dv_pay_t;

  // {clamped flag, value} for a quotient magnitude and its sign
  function automatic logic [W:0] qclamp(input logic [NB-1:0] q, input logic neg);
    logic [NB-W:0] hi;
    logic [W-2:0]  lo;
    hi = q[NB-1:W-1];
    lo = q[W-2:0];
    if (!neg) begin
      if (hi != '0) qclamp = {1'b1, WMAX};
      else          qclamp = {1'b0, q[W-1:0]};
    end else begin
      if (hi > (NB-W+1)'(1) || (hi == (NB-W+1)'(1) && lo != '0)) begin
        qclamp = {1'b1, WMIN};
      end else begin
        qclamp = {1'b0, -q[W-1:0]};
      end
    end
  endfunction

  logic               en;
  logic [3:0]         vld_r;
  v3a_op_t            op_in;

  logic signed [W-1:0]   a_in [3];
  logic signed [W-1:0]   b_in [3];
  logic [2:0][2*W-1:0]   ab_a, aa_a;
  logic signed [W-1:0]   a_d [3];
  logic signed [W-1:0]   vec_d [3];
  logic [2:0]            lsat_d;
  logic signed [W-1:0]   s_b;

  v3a_op_t               m_op_d;
  logic signed [W-1:0]   m_f_d, m_s_d;
  logic                  m_sat_d;
  logic [2*W-1:0]        m_sq_d;

  sq_pay_t               sq_pay_in, sq_pay_out;
  logic                  sq_vld;
  logic [W-1:0]          root;

  dv_pay_t               dv_pay_in, dv_pay_out;
  logic [W-1:0]          dvs;
  logic [2:0][NB-1:0]    dvd;
  logic [2:0][NB-1:0]    quo;
  logic                  dv_vld;
  logic                  is_div;
  logic [W-1:0]          f_abs;

  logic                  out_valid_r;
  logic [2:0][W-1:0]     vec_r, vec_nxt;
  logic [W-1:0]          scalar_r;
  logic                  sat_r, sat_nxt;
  logic                  dbz_r, dbz_nxt;
  logic [W:0]            qc [3];

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;
  assign op_in    = v3a_op_t'(in_operation);

  assign a_in[0] = in_a_x;
  assign a_in[1] = in_a_y;
  assign a_in[2] = in_a_z;
  assign b_in[0] = in_b_x;
  assign b_in[1] = in_b_y;
  assign b_in[2] = in_b_z;

  for (genvar l = 0; l < 3; l++) begin : g_lane
    v3a_lane #(.W(W), .F(F)) u_lane (
      .clk     (clk),
      .en      (en),
      .op_i    (op_in),
      .a_i     (a_in[l]),
      .b_i     (b_in[l]),
      .a_n1_i  (a_in[(l+1)%3]),
      .b_n1_i  (b_in[(l+1)%3]),
      .a_n2_i  (a_in[(l+2)%3]),
      .b_n2_i  (b_in[(l+2)%3]),
      .f_i     (in_factor),
      .s_b_i   (s_b),
      .ab_a_o  (ab_a[l]),
      .aa_a_o  (aa_a[l]),
      .a_d_o   (a_d[l]),
      .vec_d_o (vec_d[l]),
      .sat_d_o (lsat_d[l])
    );
  end

  v3a_merge #(.W(W), .F(F)) u_merge (
    .clk     (clk),
    .en      (en),
    .op_i    (op_in),
    .f_i     (in_factor),
    .ab_i    (ab_a),
    .aa_i    (aa_a),
    .s_b_o   (s_b),
    .op_d_o  (m_op_d),
    .f_d_o   (m_f_d),
    .s_d_o   (m_s_d),
    .sat_d_o (m_sat_d),
    .sq_d_o  (m_sq_d)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_valid};
    end
  end

  always_comb begin
    sq_pay_in.op  = m_op_d;
    sq_pay_in.sat = m_sat_d | (|lsat_d);
    sq_pay_in.s   = m_s_d;
    sq_pay_in.f   = m_f_d;
    for (int l = 0; l < 3; l++) begin
      sq_pay_in.v[l] = vec_d[l];
      sq_pay_in.a[l] = a_d[l];
    end
  end

  v3a_sqrt #(.W(W), .PW($bits(sq_pay_t))) u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (vld_r[3]),
    .rad_i   (m_sq_d),
    .pay_i   (sq_pay_in),
    .valid_o (sq_vld),
    .root_o  (root),
    .pay_o   (sq_pay_out)
  );

  // divisor is |factor| for div and the magnitude for norm
  assign is_div = (sq_pay_out.op == OP_DIV);
  assign f_abs  = sq_pay_out.f[W-1] ? -sq_pay_out.f : sq_pay_out.f;
  assign dvs    = is_div ? f_abs : root;

  always_comb begin
    dv_pay_in.op   = sq_pay_out.op;
    dv_pay_in.sat  = sq_pay_out.sat;
    dv_pay_in.s    = sq_pay_out.s;
    dv_pay_in.v    = sq_pay_out.v;
    dv_pay_in.zero = (dvs == '0);
    if (sq_pay_out.op == OP_MAG) begin
      dv_pay_in.s   = root[W-1] ? WMAX : root;
      dv_pay_in.sat = sq_pay_out.sat | root[W-1];
    end
    for (int l = 0; l < 3; l++) begin
      dvd[l] = {(sq_pay_out.a[l][W-1] ? -sq_pay_out.a[l] : sq_pay_out.a[l]),
                {F{1'b0}}};
      dv_pay_in.neg[l] = sq_pay_out.a[l][W-1] ^ (is_div & sq_pay_out.f[W-1]);
    end
  end

  v3a_div #(.W(W), .F(F), .PW($bits(dv_pay_t))) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (sq_vld),
    .dvs_i   (dvs),
    .dvd_i   (dvd),
    .pay_i   (dv_pay_in),
    .valid_o (dv_vld),
    .quo_o   (quo),
    .pay_o   (dv_pay_out)
  );

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      qc[l] = qclamp(quo[l], dv_pay_out.neg[l]);
    end
    vec_nxt = dv_pay_out.v;
    sat_nxt = dv_pay_out.sat;
    dbz_nxt = 1'b0;
    case (dv_pay_out.op)
      OP_DIV: begin
        if (dv_pay_out.zero) begin
          vec_nxt = '0;
          dbz_nxt = 1'b1;
        end else begin
          for (int l = 0; l < 3; l++) vec_nxt[l] = qc[l][W-1:0];
          sat_nxt = dv_pay_out.sat | qc[0][W] | qc[1][W] | qc[2][W];
        end
      end
      OP_NORM: begin
        if (dv_pay_out.zero) begin
          vec_nxt    = '0;
          vec_nxt[0] = NORM_ONE;
          sat_nxt    = ONE_CLAMP;
        end else begin
          for (int l = 0; l < 3; l++) vec_nxt[l] = qc[l][W-1:0];
          sat_nxt = dv_pay_out.sat | qc[0][W] | qc[1][W] | qc[2][W];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r    <= vec_nxt;
      scalar_r <= dv_pay_out.s;
      sat_r    <= sat_nxt;
      dbz_r    <= dbz_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_x              = vec_r[0];
  assign out_y              = vec_r[1];
  assign out_z              = vec_r[2];
  assign out_scalar         = scalar_r;
  assign out_saturated      = sat_r;
  assign out_divide_by_zero = dbz_r;

  // a zero divisor leaves nothing but the flag
  `V3A_ASSERT_IMP(a_dbz_zero, out_valid && out_divide_by_zero, out_x == '0 && out_y == '0 && out_z == '0 && out_scalar == '0)
  `V3A_ASSERT_IMP(a_dbz_nosat, out_valid && out_divide_by_zero, !out_saturated)
  // a stall freezes the pipeline
  `V3A_ASSERT_NXT(a_stall_hold, !en, $stable(dv_vld) && $stable(sq_vld))

endmodule
